@@ hdl/ilp_pkg.sv @@
// shared types and constants for the integer literal parser
// no dependencies; used by every file of the block

package ilp_pkg;

  localparam int unsigned VALUE_WIDTH = 64;

  // character codes the parser looks for
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [3:0] {
    PH_START,
    PH_ZERO,
    PH_DEC,
    PH_OCT,
    PH_HEX,
    PH_SFX_U,
    PH_SFX_UL,
    PH_SFX_L,
    PH_SFX_LL,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } base_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_number;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_decimal;
    logic                   has_unsigned;
    logic                   has_long;
    logic                   has_long_long;
    logic                   invalid;
  } out_item_t;

  typedef struct packed {
    phase_e                 phase;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   decimal_mark;
    logic                   unsigned_mark;
    logic                   long_mark;
    logic                   long_long_mark;
    logic                   invalid_mark;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_START,
    acc:            '0,
    decimal_mark:   1'b0,
    unsigned_mark:  1'b0,
    long_mark:      1'b0,
    long_long_mark: 1'b0,
    invalid_mark:   1'b0
  };

endpackage

@@ hdl/ilp_step.sv @@
// next-state logic of the parser for one character
// depends on ilp_pkg

module ilp_step (
  input  ilp_pkg::parse_state_t state_i,
  input  logic [7:0]            char_i,
  output ilp_pkg::parse_state_t state_o
);

  logic [7:0]                      lc;
  ilp_pkg::base_e                  base;
  logic [3:0]                      dig;
  logic                            dig_ok;
  logic [ilp_pkg::VALUE_WIDTH-1:0] acc_scaled;
  logic [ilp_pkg::VALUE_WIDTH-1:0] acc_next;

  always_comb begin
    if (char_i inside {[ilp_pkg::CH_UP_A:ilp_pkg::CH_UP_Z]}) begin
      lc = char_i + ilp_pkg::CASE_GAP;
    end else begin
      lc = char_i;
    end
  end

  // the start state reads its first digit as decimal, the zero state as octal
  always_comb begin
    case (state_i.phase)
      ilp_pkg::PH_ZERO, ilp_pkg::PH_OCT: base = ilp_pkg::BASE_8;
      ilp_pkg::PH_HEX:                   base = ilp_pkg::BASE_16;
      default:                           base = ilp_pkg::BASE_10;
    endcase
  end

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    case (base)
      ilp_pkg::BASE_8: begin
        dig_ok = char_i inside {[ilp_pkg::CH_0:ilp_pkg::CH_7]};
        dig    = char_i[3:0];
      end
      ilp_pkg::BASE_16: begin
        if (char_i inside {[ilp_pkg::CH_0:ilp_pkg::CH_9]}) begin
          dig_ok = 1'b1;
          dig    = char_i[3:0];
        end else if (lc inside {[ilp_pkg::CH_LO_A:ilp_pkg::CH_LO_F]}) begin
          dig_ok = 1'b1;
          dig    = lc[3:0] + 4'd9;
        end
      end
      default: begin
        dig_ok = char_i inside {[ilp_pkg::CH_0:ilp_pkg::CH_9]};
        dig    = char_i[3:0];
      end
    endcase
  end

  // constant bases are shifts and adds
  always_comb begin
    case (base)
      ilp_pkg::BASE_8:  acc_scaled = state_i.acc << 3;
      ilp_pkg::BASE_16: acc_scaled = state_i.acc << 4;
      default:          acc_scaled = (state_i.acc << 3) + (state_i.acc << 1);
    endcase
    acc_next = acc_scaled + {{(ilp_pkg::VALUE_WIDTH-4){1'b0}}, dig};
  end

  always_comb begin
    state_o = state_i;
    if (!state_i.invalid_mark) begin
      case (state_i.phase)
        ilp_pkg::PH_START, ilp_pkg::PH_ZERO, ilp_pkg::PH_DEC,
        ilp_pkg::PH_OCT, ilp_pkg::PH_HEX: begin
          if (state_i.phase == ilp_pkg::PH_ZERO && lc == ilp_pkg::CH_LO_X) begin
            state_o.phase = ilp_pkg::PH_HEX;
          end else if (state_i.phase == ilp_pkg::PH_START && char_i == ilp_pkg::CH_0) begin
            state_o.phase = ilp_pkg::PH_ZERO;
          end else begin
            case (state_i.phase)
              ilp_pkg::PH_START: begin
                state_o.decimal_mark = 1'b1;
                state_o.phase        = ilp_pkg::PH_DEC;
              end
              ilp_pkg::PH_ZERO: state_o.phase = ilp_pkg::PH_OCT;
              default:          state_o.phase = state_i.phase;
            endcase
            if (dig_ok) begin
              state_o.acc = acc_next;
            end else if (lc == ilp_pkg::CH_LO_U) begin
              state_o.unsigned_mark = 1'b1;
              state_o.phase         = ilp_pkg::PH_SFX_U;
            end else if (lc == ilp_pkg::CH_LO_L) begin
              state_o.long_mark = 1'b1;
              state_o.phase     = ilp_pkg::PH_SFX_L;
            end else begin
              state_o.invalid_mark = 1'b1;
              state_o.phase        = ilp_pkg::PH_DONE;
            end
          end
        end
        ilp_pkg::PH_SFX_U: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            state_o.long_mark = 1'b1;
            state_o.phase     = ilp_pkg::PH_SFX_UL;
          end else begin
            state_o.invalid_mark = 1'b1;
            state_o.phase        = ilp_pkg::PH_DONE;
          end
        end
        ilp_pkg::PH_SFX_UL: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            state_o.long_mark      = 1'b0;
            state_o.long_long_mark = 1'b1;
            state_o.phase          = ilp_pkg::PH_DONE;
          end else begin
            state_o.invalid_mark = 1'b1;
            state_o.phase        = ilp_pkg::PH_DONE;
          end
        end
        ilp_pkg::PH_SFX_L: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            state_o.long_mark      = 1'b0;
            state_o.long_long_mark = 1'b1;
            state_o.phase          = ilp_pkg::PH_SFX_LL;
          end else if (lc == ilp_pkg::CH_LO_U) begin
            state_o.unsigned_mark = 1'b1;
            state_o.phase         = ilp_pkg::PH_DONE;
          end else begin
            state_o.invalid_mark = 1'b1;
            state_o.phase        = ilp_pkg::PH_DONE;
          end
        end
        ilp_pkg::PH_SFX_LL: begin
          if (lc == ilp_pkg::CH_LO_U) begin
            state_o.unsigned_mark = 1'b1;
            state_o.phase         = ilp_pkg::PH_DONE;
          end else begin
            state_o.invalid_mark = 1'b1;
            state_o.phase        = ilp_pkg::PH_DONE;
          end
        end
        default: begin
          // anything after a complete suffix is left over
          state_o.invalid_mark = 1'b1;
          state_o.phase        = ilp_pkg::PH_DONE;
        end
      endcase
    end
  end

endmodule

@@ hdl/integer_literal_parser_unit.sv @@
// integer literal parser: one character per cycle while the input is not stalled, one result per literal
// the result appears in the output register in the cycle after the last character is accepted
// each accepted character passes the accumulate step (shift-add by the base)
// the input stalls only while a result sits in the output register and is itself stalled
// reset clears the parse state and the output valid; the output payload is not reset
// depends on ilp_pkg and ilp_step

module integer_literal_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ilp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ilp_pkg::out_item_t out_data_o
);

  ilp_pkg::parse_state_t state_q, state_d, state_step;
  ilp_pkg::out_item_t    out_data_q, out_data_d;
  logic                  out_valid_q, out_valid_d;
  logic                  in_accept;

  ilp_step u_step (
    .state_i (state_q),
    .char_i  (in_data_i.char_code),
    .state_o (state_step)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d     = state_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (in_accept) begin
      if (in_data_i.end_of_number) begin
        state_d                  = ilp_pkg::STATE_RESET;
        out_valid_d              = 1'b1;
        out_data_d.value         = state_step.acc;
        out_data_d.is_decimal    = state_step.decimal_mark;
        out_data_d.has_unsigned  = state_step.unsigned_mark;
        out_data_d.has_long      = state_step.long_mark;
        out_data_d.has_long_long = state_step.long_long_mark;
        out_data_d.invalid       = state_step.invalid_mark;
      end else begin
        state_d = state_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilp_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/ilp_checker.sv @@
// port-level checks for the integer literal parser, bound to the top level
// depends on ilp_pkg and integer_literal_parser_unit

module ilp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ilp_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ilp_pkg::out_item_t out_data_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // a new result only follows the last character of a literal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && in_data_i.end_of_number))
    else $error("result without an end-of-number item");

  // a result held over only when the last character came while draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(in_valid_i && in_data_i.end_of_number) |=> !out_valid_o)
    else $error("result repeated");

  // the input only stalls behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the output");

  // ll replaces l, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.has_long && out_data_o.has_long_long))
    else $error("long and long long both set");

endmodule

bind integer_literal_parser_unit ilp_checker u_ilp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/integer_literal_parser_unit_tb.sv @@
// testbench for integer_literal_parser_unit: sends literals one character per item and
// checks each parsed result against a predictor kept inside this file
// depends on ilp_pkg and the integer_literal_parser_unit rtl

module integer_literal_parser_unit_tb;

  localparam int unsigned RADIX_OCT = 8;
  localparam int unsigned RADIX_DEC = 10;
  localparam int unsigned RADIX_HEX = 16;
  localparam int unsigned NO_DIGIT = 255;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ilp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ilp_pkg::out_item_t out_data;

  int send_idle_pct = 30;
  int recv_stall_pct = 57;
  int err_count = 0;
  int cycle_count = 0;

  // parser state as the predictor sees it
  ilp_pkg::phase_e                 lit_phase;
  logic [ilp_pkg::VALUE_WIDTH-1:0] lit_acc;
  logic                            lit_decimal;
  logic                            lit_unsigned;
  logic                            lit_long;
  logic                            lit_long_long;
  logic                            lit_invalid;

  ilp_pkg::out_item_t pending_results[$];
  logic [7:0]         lit_chars[$];

  always #4 clk = ~clk;

  integer_literal_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= ilp_pkg::CH_UP_A && c <= ilp_pkg::CH_UP_Z) ? c + ilp_pkg::CASE_GAP : c;
  endfunction

  function automatic int unsigned digit_value(input logic [7:0] c, input int unsigned radix);
    int unsigned d;
    logic [7:0]  lc;
    d = NO_DIGIT;
    lc = fold_case(c);
    if (c >= ilp_pkg::CH_0 && c <= ilp_pkg::CH_9) d = 32'(c - ilp_pkg::CH_0);
    else if (lc >= ilp_pkg::CH_LO_A && lc <= ilp_pkg::CH_LO_F)
      d = 32'(lc - ilp_pkg::CH_LO_A) + 10;
    return (d < radix) ? d : NO_DIGIT;
  endfunction

  function void clear_literal();
    lit_phase = ilp_pkg::PH_START;
    lit_acc = '0;
    lit_decimal = 1'b0;
    lit_unsigned = 1'b0;
    lit_long = 1'b0;
    lit_long_long = 1'b0;
    lit_invalid = 1'b0;
  endfunction

  function void mark_leftover();
    lit_invalid = 1'b1;
    lit_phase = ilp_pkg::PH_DONE;
  endfunction

  function void begin_suffix(input logic [7:0] lc);
    if (lc == ilp_pkg::CH_LO_U) begin
      lit_unsigned = 1'b1;
      lit_phase = ilp_pkg::PH_SFX_U;
    end else if (lc == ilp_pkg::CH_LO_L) begin
      lit_long = 1'b1;
      lit_phase = ilp_pkg::PH_SFX_L;
    end else begin
      mark_leftover();
    end
  endfunction

  function void take_digit(input logic [7:0] c, input int unsigned radix);
    int unsigned d;
    d = digit_value(c, radix);
    if (d != NO_DIGIT) lit_acc = lit_acc * radix + d;
    else begin_suffix(fold_case(c));
  endfunction

  // advance the predicted parse by one character; queue a result on the last one
  function void absorb_char(input logic [7:0] c, input logic last);
    logic [7:0] lc;
    lc = fold_case(c);
    if (!lit_invalid) begin
      case (lit_phase)
        ilp_pkg::PH_START: begin
          if (c == ilp_pkg::CH_0) begin
            lit_phase = ilp_pkg::PH_ZERO;
          end else begin
            lit_decimal = 1'b1;
            lit_phase = ilp_pkg::PH_DEC;
            take_digit(c, RADIX_DEC);
          end
        end
        ilp_pkg::PH_ZERO: begin
          if (lc == ilp_pkg::CH_LO_X) begin
            lit_phase = ilp_pkg::PH_HEX;
          end else begin
            lit_phase = ilp_pkg::PH_OCT;
            take_digit(c, RADIX_OCT);
          end
        end
        ilp_pkg::PH_DEC: take_digit(c, RADIX_DEC);
        ilp_pkg::PH_OCT: take_digit(c, RADIX_OCT);
        ilp_pkg::PH_HEX: take_digit(c, RADIX_HEX);
        ilp_pkg::PH_SFX_U: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            lit_long = 1'b1;
            lit_phase = ilp_pkg::PH_SFX_UL;
          end else begin
            mark_leftover();
          end
        end
        ilp_pkg::PH_SFX_UL: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            lit_long = 1'b0;
            lit_long_long = 1'b1;
            lit_phase = ilp_pkg::PH_DONE;
          end else begin
            mark_leftover();
          end
        end
        ilp_pkg::PH_SFX_L: begin
          if (lc == ilp_pkg::CH_LO_L) begin
            lit_long = 1'b0;
            lit_long_long = 1'b1;
            lit_phase = ilp_pkg::PH_SFX_LL;
          end else if (lc == ilp_pkg::CH_LO_U) begin
            lit_unsigned = 1'b1;
            lit_phase = ilp_pkg::PH_DONE;
          end else begin
            mark_leftover();
          end
        end
        ilp_pkg::PH_SFX_LL: begin
          if (lc == ilp_pkg::CH_LO_U) begin
            lit_unsigned = 1'b1;
            lit_phase = ilp_pkg::PH_DONE;
          end else begin
            mark_leftover();
          end
        end
        default: mark_leftover();
      endcase
    end
    if (last) begin
      pending_results.push_back('{value: lit_acc, is_decimal: lit_decimal,
                                  has_unsigned: lit_unsigned, has_long: lit_long,
                                  has_long_long: lit_long_long, invalid: lit_invalid});
      clear_literal();
    end
  endfunction

  // valid stays high after acceptance; whoever lets time pass next lowers it first
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, end_of_number: last};
    do @(posedge clk); while (in_stall);
    absorb_char(c, last);
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_chars.size(); i++)
      send_char(lit_chars[i], i == lit_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    lit_chars.delete();
    for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
    send_literal();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // mostly well-formed literals with random digits and suffix case, some noise
  function void build_literal();
    int unsigned kind;
    int unsigned ndig;
    int unsigned v;
    int unsigned pos;
    string       sfx;
    lit_chars.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(255)));
      return;
    end
    ndig = ($urandom_range(9) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 8);
    if (kind < 45) begin
      for (int i = 0; i < ndig; i++)
        lit_chars.push_back(8'(ilp_pkg::CH_0 +
                               ((i == 0) ? $urandom_range(1, 9) : $urandom_range(9))));
    end else if (kind < 70) begin
      lit_chars.push_back(ilp_pkg::CH_0);
      // now and then an 8 or 9 slips into an octal literal
      for (int i = 0; i < ndig; i++)
        lit_chars.push_back(8'(ilp_pkg::CH_0 +
                               $urandom_range(($urandom_range(19) == 0) ? 9 : 7)));
    end else begin
      lit_chars.push_back(ilp_pkg::CH_0);
      lit_chars.push_back($urandom_range(1) ? ilp_pkg::CH_LO_X
                                            : ilp_pkg::CH_LO_X - ilp_pkg::CASE_GAP);
      for (int i = 0; i < ndig; i++) begin
        v = $urandom_range(15);
        if (v < 10) lit_chars.push_back(8'(ilp_pkg::CH_0 + v));
        else lit_chars.push_back(8'(($urandom_range(1) ? ilp_pkg::CH_LO_A
                                                       : ilp_pkg::CH_UP_A) + v - 10));
      end
    end
    case ($urandom_range(7))
      0: sfx = "";
      1: sfx = "u";
      2: sfx = "ul";
      3: sfx = "ull";
      4: sfx = "l";
      5: sfx = "ll";
      6: sfx = "lu";
      default: sfx = "llu";
    endcase
    for (int i = 0; i < sfx.len(); i++)
      lit_chars.push_back($urandom_range(1) ? sfx[i] - ilp_pkg::CASE_GAP : sfx[i]);
    if ($urandom_range(99) < 12) begin
      pos = $urandom_range(lit_chars.size());
      lit_chars.insert(pos, 8'($urandom_range(255)));
    end
    if (lit_chars.size() == 0) lit_chars.push_back(ilp_pkg::CH_0);
  endfunction

  task automatic test_special_cases();
    send_text("0");
    send_text("0x");
    send_text("08");
    send_text("u");
    lit_chars.delete();
    lit_chars.push_back(8'h00);
    send_literal();
    lit_chars.delete();
    lit_chars.push_back(ilp_pkg::CH_9);
    lit_chars.push_back(8'hff);
    send_literal();
    send_text("7LlU");
    send_text("0XfuL");
    send_text("1lu");
    send_text("2ulL");
  endtask

  task automatic test_value_wrap();
    send_text("0xffffffffffffffff");
    send_text("0XFFFFFFFFFFFFFFFFFFFF");
    send_text("18446744073709551616");
    send_text("18446744073709551615ULL");
    send_text("07777777777777777777777u");
  endtask

  task automatic test_random_literals(input int unsigned char_count);
    int unsigned sent;
    sent = 0;
    while (sent < char_count) begin
      build_literal();
      sent += lit_chars.size();
      send_literal();
    end
  endtask

  function void compare_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ilp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("value", 64'(want.value), 64'(out_data.value));
        compare_field("is_decimal", 64'(want.is_decimal), 64'(out_data.is_decimal));
        compare_field("has_unsigned", 64'(want.has_unsigned), 64'(out_data.has_unsigned));
        compare_field("has_long", 64'(want.has_long), 64'(out_data.has_long));
        compare_field("has_long_long", 64'(want.has_long_long),
                      64'(out_data.has_long_long));
        compare_field("invalid", 64'(want.invalid), 64'(out_data.invalid));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_literal_parser_unit test failed");
      $finish;
    end
  end

  initial begin
    clear_literal();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_value_wrap();
    test_random_literals(560);
    // sender holds off until the output side has caught up
    wait_for_results();
    send_idle_pct = 57;
    recv_stall_pct = 30;
    test_random_literals(560);
    wait_for_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_literals(600);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("integer_literal_parser_unit test passed");
    end else begin
      $display("integer_literal_parser_unit test failed");
    end
    $finish;
  end

endmodule

@@ integer_literal_parser_unit.f @@
hdl/ilp_pkg.sv
hdl/ilp_step.sv
hdl/integer_literal_parser_unit.sv
hdl/ilp_checker.sv
test/integer_literal_parser_unit_tb.sv
